[rtl/vpgd_pkg.sv]
// ----------------------------------------------------------------------------
// vpgd_pkg
// Types, tables and helpers shared by the scan packet glyph decoder.
// ----------------------------------------------------------------------------
package vpgd_pkg;

  localparam int SLOTS      = 47;
  localparam int FONT_SIZE  = 101;
  localparam int ROW_W      = 5;
  localparam int ROWS       = 7;
  localparam int GLYPH_W    = ROW_W * ROWS;
  localparam int SLOT_W     = 6;
  localparam int CODE_W     = 8;
  localparam int GROUP      = 8;
  localparam int NGROUPS    = (FONT_SIZE + GROUP - 1) / GROUP;

  localparam logic [CODE_W-1:0] NO_MATCH = 8'h3F;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [7:0]        byte0;
    logic [7:0]        byte1;
    logic [7:0]        byte2;
    logic [7:0]        byte3;
    logic [7:0]        byte4;
  } in_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  position;
    logic [CODE_W-1:0]  char_code;
    logic               annunciator;
    logic [GLYPH_W-1:0] glyph_rows;
  } out_rsp_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  position;
    logic               annunciator;
    logic [GLYPH_W-1:0] glyph_rows;
  } dec_t;

  typedef struct packed {
    dec_t                 dec;
    logic [FONT_SIZE-1:0] hits;
  } match_t;

  typedef struct packed {
    dec_t                           dec;
    logic [NGROUPS-1:0]             grp_hit;
    logic [NGROUPS-1:0][CODE_W-1:0] grp_code;
  } grp_t;

  localparam logic [SLOT_W-1:0] SLOT_POS [SLOTS] = '{
    6'd8,  6'd7,  6'd6,  6'd5,  6'd4,  6'd3,  6'd2,  6'd1,  6'd0,  6'd18,
    6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28,
    6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd17, 6'd16, 6'd15,
    6'd14, 6'd13, 6'd12, 6'd11, 6'd10, 6'd9,  6'd46, 6'd45, 6'd44, 6'd43,
    6'd42, 6'd41, 6'd40, 6'd39, 6'd38, 6'd37, 6'd36
  };

  localparam logic [GLYPH_W-1:0] FONT_GLYPH [FONT_SIZE] = '{
    {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00}, {5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04},
    {5'h0A,5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00}, {5'h0A,5'h0A,5'h1F,5'h0A,5'h1F,5'h0A,5'h0A},
    {5'h04,5'h0F,5'h14,5'h0E,5'h05,5'h1E,5'h04}, {5'h19,5'h19,5'h02,5'h04,5'h08,5'h13,5'h13},
    {5'h04,5'h0A,5'h0A,5'h0A,5'h15,5'h12,5'h0D}, {5'h04,5'h04,5'h08,5'h00,5'h00,5'h00,5'h00},
    {5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02}, {5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08},
    {5'h00,5'h04,5'h15,5'h0E,5'h15,5'h04,5'h00}, {5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00},
    {5'h00,5'h00,5'h00,5'h00,5'h0C,5'h04,5'h08}, {5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00},
    {5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C}, {5'h01,5'h01,5'h02,5'h04,5'h08,5'h10,5'h10},
    {5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E}, {5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
    {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F}, {5'h1F,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0E},
    {5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02}, {5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E},
    {5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E}, {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
    {5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E}, {5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C},
    {5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h0C,5'h00}, {5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h04,5'h08},
    {5'h00,5'h02,5'h06,5'h0E,5'h06,5'h02,5'h00}, {5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00},
    {5'h00,5'h08,5'h0C,5'h0E,5'h0C,5'h08,5'h00}, {5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04},
    {5'h0E,5'h11,5'h17,5'h15,5'h17,5'h10,5'h0F}, {5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
    {5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E}, {5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E},
    {5'h1C,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1C}, {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F},
    {5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10}, {5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F},
    {5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11}, {5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
    {5'h02,5'h04,5'h04,5'h04,5'h04,5'h04,5'h02}, {5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
    {5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F}, {5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11},
    {5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11}, {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
    {5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10}, {5'h0E,5'h11,5'h11,5'h11,5'h15,5'h13,5'h0D},
    {5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11}, {5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E},
    {5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04}, {5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
    {5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04}, {5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A},
    {5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11}, {5'h11,5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04},
    {5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F}, {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
    {5'h10,5'h08,5'h04,5'h02,5'h01,5'h02,5'h04}, {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
    {5'h00,5'h10,5'h08,5'h04,5'h02,5'h01,5'h01}, {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F},
    {5'h01,5'h02,5'h04,5'h00,5'h00,5'h00,5'h00}, {5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F},
    {5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h0E}, {5'h00,5'h00,5'h0F,5'h10,5'h10,5'h10,5'h0F},
    {5'h01,5'h01,5'h01,5'h0F,5'h11,5'h11,5'h0F}, {5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0F},
    {5'h06,5'h09,5'h08,5'h1C,5'h08,5'h08,5'h08}, {5'h00,5'h00,5'h0F,5'h11,5'h0F,5'h01,5'h1F},
    {5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h11}, {5'h00,5'h04,5'h00,5'h04,5'h04,5'h04,5'h04},
    {5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C}, {5'h08,5'h08,5'h09,5'h0A,5'h0C,5'h0A,5'h09},
    {5'h18,5'h08,5'h08,5'h08,5'h08,5'h08,5'h1C}, {5'h00,5'h00,5'h1A,5'h15,5'h15,5'h15,5'h11},
    {5'h00,5'h00,5'h16,5'h19,5'h11,5'h11,5'h11}, {5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E},
    {5'h00,5'h00,5'h1E,5'h11,5'h1E,5'h10,5'h10}, {5'h00,5'h00,5'h0D,5'h13,5'h0F,5'h01,5'h01},
    {5'h00,5'h00,5'h16,5'h19,5'h10,5'h10,5'h10}, {5'h00,5'h00,5'h0E,5'h10,5'h0E,5'h01,5'h1E},
    {5'h04,5'h04,5'h1F,5'h04,5'h04,5'h05,5'h02}, {5'h00,5'h00,5'h11,5'h11,5'h11,5'h13,5'h0D},
    {5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04}, {5'h00,5'h00,5'h11,5'h11,5'h15,5'h15,5'h0A},
    {5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11}, {5'h00,5'h00,5'h11,5'h11,5'h0F,5'h01,5'h1E},
    {5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F}, {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
    {5'h01,5'h02,5'h04,5'h00,5'h04,5'h02,5'h01}, {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
    {5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00}, {5'h00,5'h01,5'h02,5'h04,5'h08,5'h10,5'h00},
    {5'h06,5'h09,5'h09,5'h06,5'h00,5'h00,5'h00}, {5'h0E,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h1B},
    {5'h11,5'h12,5'h14,5'h0B,5'h11,5'h02,5'h03}, {5'h00,5'h00,5'h04,5'h0E,5'h1F,5'h00,5'h00},
    {5'h00,5'h00,5'h1F,5'h0E,5'h04,5'h00,5'h00}
  };

  localparam logic [CODE_W-1:0] FONT_CODE [FONT_SIZE] = '{
    8'h20,8'h21,8'h22,8'h23,8'h24,8'h25,8'h26,8'h27,8'h28,8'h29,8'h2A,8'h2B,8'h2C,8'h2D,
    8'h2E,8'h2F,8'h30,8'h31,8'h32,8'h33,8'h34,8'h35,8'h36,8'h37,8'h38,8'h39,8'h3A,8'h3B,
    8'h11,8'h3D,8'h10,8'h3F,8'h40,8'h41,8'h42,8'h43,8'h44,8'h45,8'h46,8'h47,8'h48,8'h49,
    8'h4A,8'h4B,8'h4C,8'h4D,8'h4E,8'h4F,8'h50,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
    8'h58,8'h59,8'h5A,8'h5B,8'h5C,8'h5D,8'h5E,8'h5F,8'h60,8'h61,8'h62,8'h63,8'h64,8'h65,
    8'h66,8'h67,8'h68,8'h69,8'h6A,8'h6B,8'h6C,8'h6D,8'h6E,8'h6F,8'h70,8'h71,8'h72,8'h73,
    8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7A,8'h7B,8'h7C,8'h7D,8'h7E,8'h2F,8'hB0,8'h24,
    8'hBD,8'h1E,8'h1F
  };

  function automatic logic [ROW_W-1:0] rev5(logic [ROW_W-1:0] v);
    logic [ROW_W-1:0] r;
    for (int k = 0; k < ROW_W; k++) begin
      r[k] = v[ROW_W-1-k];
    end
    return r;
  endfunction

  function automatic logic [SLOT_W-1:0] slot_pos(logic [SLOT_W-1:0] slot);
    logic [SLOT_W-1:0] p;
    p = slot;
    if (slot < SLOT_W'(SLOTS)) begin
      p = SLOT_POS[slot];
    end
    return p;
  endfunction

endpackage

[rtl/vpgd_unscramble.sv]
// ----------------------------------------------------------------------------
// vpgd_unscramble
// First stage: gathers the seven glyph rows, the annunciator and the position.
// ----------------------------------------------------------------------------
module vpgd_unscramble (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  vpgd_pkg::in_req_t req_i,
  output logic              valid_o,
  input  logic              ready_i,
  output vpgd_pkg::dec_t    dec_o
);

  logic           valid_q;
  vpgd_pkg::dec_t dec_d;
  vpgd_pkg::dec_t dec_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    dec_d.position    = vpgd_pkg::slot_pos(req_i.slot);
    dec_d.annunciator = req_i.byte2[6];
    dec_d.glyph_rows  = {
      vpgd_pkg::rev5({req_i.byte1[3:0], req_i.byte2[7]}),
      vpgd_pkg::rev5({req_i.byte0[0], req_i.byte1[7:4]}),
      vpgd_pkg::rev5(req_i.byte0[5:1]),
      vpgd_pkg::rev5({req_i.byte4[2:0], req_i.byte0[7:6]}),
      vpgd_pkg::rev5(req_i.byte4[7:3]),
      vpgd_pkg::rev5(req_i.byte3[4:0]),
      vpgd_pkg::rev5({req_i.byte2[1:0], req_i.byte3[7:5]})
    };
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      dec_q <= dec_d;
    end
  end

  assign valid_o = valid_q;
  assign dec_o   = dec_q;

endmodule

[rtl/vpgd_match.sv]
// ----------------------------------------------------------------------------
// vpgd_match
// Second stage: compares the glyph against every font entry in parallel.
// ----------------------------------------------------------------------------
module vpgd_match (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  vpgd_pkg::dec_t   dec_i,
  output logic             valid_o,
  input  logic             ready_i,
  output vpgd_pkg::match_t match_o
);

  logic             valid_q;
  vpgd_pkg::match_t match_d;
  vpgd_pkg::match_t match_q;

  assign ready_o = !valid_q || ready_i;

  always_comb begin
    match_d.dec = dec_i;
    for (int i = 0; i < vpgd_pkg::FONT_SIZE; i++) begin
      match_d.hits[i] = (dec_i.glyph_rows == vpgd_pkg::FONT_GLYPH[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      match_q <= match_d;
    end
  end

  assign valid_o = valid_q;
  assign match_o = match_q;

endmodule

[rtl/vpgd_encode.sv]
// ----------------------------------------------------------------------------
// vpgd_encode
// Third and fourth stages: first-match priority encode, per group then across
// groups, into the character code.
// ----------------------------------------------------------------------------
module vpgd_encode (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  vpgd_pkg::match_t   match_i,
  output logic               valid_o,
  input  logic               ready_i,
  output vpgd_pkg::out_rsp_t rsp_o
);

  logic               grp_valid_q;
  logic               grp_ready;
  vpgd_pkg::grp_t     grp_d;
  vpgd_pkg::grp_t     grp_q;
  logic               rsp_valid_q;
  vpgd_pkg::out_rsp_t rsp_d;
  vpgd_pkg::out_rsp_t rsp_q;

  assign grp_ready = !rsp_valid_q || ready_i;
  assign ready_o   = !grp_valid_q || grp_ready;

  // per-group first match; scan from the top so the lowest index wins
  always_comb begin
    grp_d.dec = match_i.dec;
    for (int g = 0; g < vpgd_pkg::NGROUPS; g++) begin
      grp_d.grp_hit[g]  = 1'b0;
      grp_d.grp_code[g] = vpgd_pkg::NO_MATCH;
      for (int j = vpgd_pkg::GROUP - 1; j >= 0; j--) begin
        if (g * vpgd_pkg::GROUP + j < vpgd_pkg::FONT_SIZE) begin
          if (match_i.hits[g * vpgd_pkg::GROUP + j]) begin
            grp_d.grp_hit[g]  = 1'b1;
            grp_d.grp_code[g] = vpgd_pkg::FONT_CODE[g * vpgd_pkg::GROUP + j];
          end
        end
      end
    end
  end

  always_comb begin
    rsp_d.position    = grp_q.dec.position;
    rsp_d.annunciator = grp_q.dec.annunciator;
    rsp_d.glyph_rows  = grp_q.dec.glyph_rows;
    rsp_d.char_code   = vpgd_pkg::NO_MATCH;
    for (int g = vpgd_pkg::NGROUPS - 1; g >= 0; g--) begin
      if (grp_q.grp_hit[g]) begin
        rsp_d.char_code = grp_q.grp_code[g];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grp_valid_q <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        grp_valid_q <= valid_i;
      end
      if (grp_ready) begin
        rsp_valid_q <= grp_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      grp_q <= grp_d;
    end
    if (grp_valid_q && grp_ready) begin
      rsp_q <= rsp_d;
    end
  end

  assign valid_o = rsp_valid_q;
  assign rsp_o   = rsp_q;

endmodule

[rtl/vfd_packet_glyph_decoder_top.sv]
// Pipeline: four register stages (decode, match, group encode, final select).
// Throughput: one request per cycle; every stage holds under output stall.
// Reset: asynchronous, clears all stage valid bits; no other state.
// ----------------------------------------------------------------------------
// vfd_packet_glyph_decoder_top
// Decodes a display scan packet: glyph rows, annunciator, position, char code.
// ----------------------------------------------------------------------------
module vfd_packet_glyph_decoder_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vpgd_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vpgd_pkg::out_rsp_t out_rsp_o
);

  logic             dec_valid;
  logic             dec_ready;
  vpgd_pkg::dec_t   dec;
  logic             mat_valid;
  logic             mat_ready;
  vpgd_pkg::match_t mat;

  vpgd_unscramble u_unscramble (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .req_i   (in_req_i),
    .valid_o (dec_valid),
    .ready_i (dec_ready),
    .dec_o   (dec)
  );

  vpgd_match u_match (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dec_valid),
    .ready_o (dec_ready),
    .dec_i   (dec),
    .valid_o (mat_valid),
    .ready_i (mat_ready),
    .match_o (mat)
  );

  vpgd_encode u_encode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mat_valid),
    .ready_o (mat_ready),
    .match_i (mat),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .rsp_o   (out_rsp_o)
  );

endmodule
